[hw/rtl/snmp_ber_pkg.sv]
// shared types, tag constants and result record for the snmp response ber parser
// no dependencies; imported by every module of the block
`default_nettype none

package snmp_ber_pkg;

    localparam int MAX_PACKET_DEF = 256;
    localparam int RES_FIFO_DEPTH = 4;

    localparam logic [7:0] TAG_SEQUENCE = 8'h30;
    localparam logic [7:0] TAG_INTEGER  = 8'h02;
    localparam logic [7:0] TAG_OCTETS   = 8'h04;
    localparam logic [7:0] TAG_GET_RESP = 8'hA2;
    localparam logic [7:0] TAG_OID      = 8'h06;
    localparam logic [7:0] TAG_ANY      = 8'h00;
    localparam logic [7:0] CHAR_DOT     = 8'h2E;
    localparam logic [7:0] PRINT_LO     = 8'h20;
    localparam logic [7:0] PRINT_END    = 8'h7F;
    localparam logic [7:0] TEXT_LIMIT_RST = 8'd120;

    localparam logic KIND_TEXT    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TAG,
        ST_LEN,
        ST_LEXT,
        ST_SKIP,
        ST_TEXT,
        ST_DONE,
        ST_FAIL
    } stage_t;

    typedef enum logic [3:0] {
        EL_OUTER,
        EL_VER,
        EL_COMM,
        EL_PDU,
        EL_INT,
        EL_LIST,
        EL_BIND,
        EL_OID,
        EL_VAL
    } elem_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic [8:0] packet_length;
    } in_item_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] ch;
        logic       ok;
        logic       found;
        logic [7:0] len;
        logic       last;
    } result_t;

    function automatic logic [7:0] want_tag(input elem_t el);
        logic [7:0] t;
        unique case (el)
            EL_OUTER: t = TAG_SEQUENCE;
            EL_VER:   t = TAG_INTEGER;
            EL_COMM:  t = TAG_OCTETS;
            EL_PDU:   t = TAG_GET_RESP;
            EL_INT:   t = TAG_INTEGER;
            EL_LIST:  t = TAG_SEQUENCE;
            EL_BIND:  t = TAG_SEQUENCE;
            EL_OID:   t = TAG_OID;
            default:  t = TAG_ANY;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/snmp_ber_parse.sv]
// ber walk state and combinational next-state logic, one packet byte per fire
// depends on snmp_ber_pkg
`default_nettype none

module snmp_ber_parse
    import snmp_ber_pkg::*;
#(
    parameter int MAX_PACKET = MAX_PACKET_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       fire,
    input  wire in_item_t   item,
    input  wire logic [7:0] text_limit,
    output logic [1:0]      res_cnt,
    output result_t         res0,
    output result_t         res1
);

    localparam int PW = $clog2(MAX_PACKET + 1);
    localparam int EW = ((PW > 16) ? PW : 16) + 2;

    stage_t          stage_reg, stage_next;
    elem_t           elem_reg, elem_next;
    logic [PW-1:0]   pos_reg, pos_next;
    logic [PW-1:0]   held_reg, held_next;
    logic [1:0]      icnt_reg, icnt_next;
    logic [7:0]      tcnt_reg, tcnt_next;
    logic            tflag_reg, tflag_next;
    logic [7:0]      tag_reg, tag_next;
    logic [15:0]     accum_reg, accum_next;
    logic [1:0]      left_reg, left_next;
    logic [PW-1:0]   outer_reg, outer_next;
    logic [PW-1:0]   pdu_reg, pdu_next;
    logic [PW-1:0]   list_reg, list_next;
    logic [PW-1:0]   bind_reg, bind_next;
    logic [PW-1:0]   skip_reg, skip_next;

    logic            active;
    logic [7:0]      b;
    stage_t          c_stage;
    elem_t           c_elem;
    logic [PW-1:0]   c_pos;
    logic [PW-1:0]   c_held;
    logic [1:0]      c_icnt;
    logic [7:0]      c_tcnt;
    logic            c_tflag;
    logic [PW-1:0]   bound;
    logic [EW-1:0]   pos_e;
    logic [EW-1:0]   bound_e;
    logic [EW-1:0]   skip_e;
    logic [EW-1:0]   end_e;
    logic [15:0]     acc_new;
    logic [15:0]     len_val;
    logic            do_accept;
    logic            got_char;
    logic [7:0]      char_val;
    logic            verdict;
    logic            ok;
    logic [1:0]      icnt_inc;

    assign b      = item.data_byte;
    assign active = fire && (item.first_byte || (stage_reg != ST_IDLE));

    always_comb
    begin
        c_stage = stage_reg;
        c_elem  = elem_reg;
        c_pos   = pos_reg;
        c_held  = held_reg;
        c_icnt  = icnt_reg;
        c_tcnt  = tcnt_reg;
        c_tflag = tflag_reg;
        if (item.first_byte)
        begin
            if (item.packet_length == 9'd0)
            begin
                c_held = PW'(1);
            end
            else if (32'(item.packet_length) > MAX_PACKET)
            begin
                c_held = PW'(MAX_PACKET);
            end
            else
            begin
                c_held = PW'(item.packet_length);
            end
            c_stage = ST_TAG;
            c_elem  = EL_OUTER;
            c_pos   = '0;
            c_icnt  = '0;
            c_tcnt  = '0;
            c_tflag = 1'b0;
        end

        unique case (c_elem)
            EL_OUTER:                bound = c_held;
            EL_VER, EL_COMM, EL_PDU: bound = outer_reg;
            EL_INT, EL_LIST:         bound = pdu_reg;
            EL_BIND:                 bound = list_reg;
            default:                 bound = bind_reg;
        endcase

        pos_e   = EW'(c_pos);
        bound_e = EW'(bound);
        skip_e  = EW'(skip_reg);
        acc_new = {accum_reg[7:0], b};
        len_val = (c_stage == ST_LEXT) ? acc_new : {8'h00, b};
        end_e   = pos_e + EW'(1) + EW'(len_val);

        stage_next = c_stage;
        elem_next  = c_elem;
        pos_next   = c_pos;
        held_next  = c_held;
        icnt_next  = c_icnt;
        tcnt_next  = c_tcnt;
        tflag_next = c_tflag;
        tag_next   = tag_reg;
        accum_next = accum_reg;
        left_next  = left_reg;
        outer_next = outer_reg;
        pdu_next   = pdu_reg;
        list_next  = list_reg;
        bind_next  = bind_reg;
        skip_next  = skip_reg;
        do_accept  = 1'b0;
        got_char   = 1'b0;
        char_val   = '0;
        icnt_inc   = c_icnt + 2'd1;

        unique case (c_stage)
            ST_TAG:
            begin
                if (pos_e + EW'(2) > bound_e)
                begin
                    stage_next = ST_FAIL;
                end
                else
                begin
                    tag_next = b;
                    if ((c_elem != EL_VAL) && (b != want_tag(c_elem)))
                    begin
                        stage_next = ST_FAIL;
                    end
                    else
                    begin
                        stage_next = ST_LEN;
                    end
                end
            end
            ST_LEN:
            begin
                if (!b[7])
                begin
                    do_accept = 1'b1;
                end
                else if ((b[6:0] == 7'd0) || (b[6:0] > 7'd2) ||
                         (pos_e + EW'(1) + EW'(b[6:0]) > bound_e))
                begin
                    stage_next = ST_FAIL;
                end
                else
                begin
                    left_next  = b[1:0];
                    accum_next = '0;
                    stage_next = ST_LEXT;
                end
            end
            ST_LEXT:
            begin
                accum_next = acc_new;
                left_next  = left_reg - 2'd1;
                if (left_reg == 2'd1)
                begin
                    do_accept = 1'b1;
                end
            end
            ST_SKIP:
            begin
                if (pos_e + EW'(1) >= skip_e)
                begin
                    stage_next = ST_TAG;
                end
            end
            ST_TEXT:
            begin
                if (c_tcnt < text_limit)
                begin
                    got_char  = 1'b1;
                    char_val  = ((b >= PRINT_LO) && (b < PRINT_END)) ? b : CHAR_DOT;
                    tcnt_next = c_tcnt + 8'd1;
                end
                if (pos_e + EW'(1) >= skip_e)
                begin
                    stage_next = ST_DONE;
                end
            end
            default:
            begin
            end
        endcase

        if (do_accept)
        begin
            if (end_e > bound_e)
            begin
                stage_next = ST_FAIL;
            end
            else
            begin
                unique case (c_elem)
                    EL_OUTER:
                    begin
                        outer_next = PW'(end_e);
                        elem_next  = EL_VER;
                        stage_next = ST_TAG;
                    end
                    EL_PDU:
                    begin
                        pdu_next   = PW'(end_e);
                        elem_next  = EL_INT;
                        stage_next = ST_TAG;
                    end
                    EL_LIST:
                    begin
                        list_next  = PW'(end_e);
                        elem_next  = EL_BIND;
                        stage_next = ST_TAG;
                    end
                    EL_BIND:
                    begin
                        bind_next  = PW'(end_e);
                        elem_next  = EL_OID;
                        stage_next = ST_TAG;
                    end
                    EL_VER, EL_COMM, EL_INT, EL_OID:
                    begin
                        skip_next  = PW'(end_e);
                        stage_next = (len_val == 16'd0) ? ST_TAG : ST_SKIP;
                        if (c_elem == EL_VER)
                        begin
                            elem_next = EL_COMM;
                        end
                        else if (c_elem == EL_COMM)
                        begin
                            elem_next = EL_PDU;
                        end
                        else if (c_elem == EL_OID)
                        begin
                            elem_next = EL_VAL;
                        end
                        else
                        begin
                            icnt_next = icnt_inc;
                            elem_next = (icnt_inc == 2'd3) ? EL_LIST : EL_INT;
                        end
                    end
                    default:
                    begin
                        if (tag_reg == TAG_OCTETS)
                        begin
                            tflag_next = 1'b1;
                            skip_next  = PW'(end_e);
                            stage_next = (len_val == 16'd0) ? ST_DONE : ST_TEXT;
                        end
                        else
                        begin
                            stage_next = ST_DONE;
                        end
                    end
                endcase
            end
        end

        verdict = (pos_e + EW'(1) >= EW'(c_held));
        ok      = (stage_next == ST_TEXT) || (stage_next == ST_DONE);
        if (verdict)
        begin
            stage_next = ST_IDLE;
        end
        else
        begin
            pos_next = c_pos + PW'(1);
        end

        res0 = '0;
        res1 = '0;
        res_cnt = 2'd0;
        if (active)
        begin
            if (got_char)
            begin
                res0.kind = KIND_TEXT;
                res0.ch   = char_val;
                res0.last = !verdict;
                if (verdict)
                begin
                    res1.kind  = KIND_VERDICT;
                    res1.ok    = ok;
                    res1.found = ok && tflag_next;
                    res1.len   = ok ? tcnt_next : 8'd0;
                    res1.last  = 1'b1;
                    res_cnt    = 2'd2;
                end
                else
                begin
                    res_cnt = 2'd1;
                end
            end
            else if (verdict)
            begin
                res0.kind  = KIND_VERDICT;
                res0.ok    = ok;
                res0.found = ok && tflag_next;
                res0.len   = ok ? tcnt_next : 8'd0;
                res0.last  = 1'b1;
                res_cnt    = 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= ST_IDLE;
            elem_reg  <= EL_OUTER;
            pos_reg   <= '0;
            held_reg  <= '0;
            icnt_reg  <= '0;
            tcnt_reg  <= '0;
            tflag_reg <= 1'b0;
            left_reg  <= '0;
        end
        else if (active)
        begin
            stage_reg <= stage_next;
            elem_reg  <= elem_next;
            pos_reg   <= pos_next;
            held_reg  <= held_next;
            icnt_reg  <= icnt_next;
            tcnt_reg  <= tcnt_next;
            tflag_reg <= tflag_next;
            left_reg  <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (active)
        begin
            tag_reg   <= tag_next;
            accum_reg <= accum_next;
            outer_reg <= outer_next;
            pdu_reg   <= pdu_next;
            list_reg  <= list_next;
            bind_reg  <= bind_next;
            skip_reg  <= skip_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/snmp_ber_fifo.sv]
// small result queue taking up to two records per cycle, one out per transfer
// depends on snmp_ber_pkg
`default_nettype none

module snmp_ber_fifo
    import snmp_ber_pkg::*;
#(
    parameter int DEPTH = RES_FIFO_DEPTH
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [1:0] push_cnt,
    input  wire result_t    wr0,
    input  wire result_t    wr1,
    output logic            room,
    output logic            out_valid,
    input  wire logic       out_ready,
    output result_t         head
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    result_t        mem_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [AW-1:0]  wr_ptr_inc;
    logic           pop;

    assign room       = (count_reg <= CW'(DEPTH - 2));
    assign out_valid  = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign pop        = out_valid && out_ready;
    assign wr_ptr_inc = wr_ptr_reg + AW'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + AW'(push_cnt);
        rd_ptr_next = pop ? (rd_ptr_reg + AW'(1)) : rd_ptr_reg;
        count_next  = count_reg + CW'(push_cnt) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= wr0;
        end
        if (push_cnt == 2'd2)
        begin
            mem_reg[wr_ptr_inc] <= wr1;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push_cnt != 2'd0) |-> (count_reg <= CW'(DEPTH - 2)))
        else $error("result queue written without room");

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("result queue level out of range");

    a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && (push_cnt == 2'd0)) |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("result queue level did not drop on transfer");

endmodule

`default_nettype wire

[hw/rtl/snmp_response_ber_parser_unit.sv]
// top level: input register, text limit register, ber parser and result queue
// depends on snmp_ber_pkg, snmp_ber_parse and snmp_ber_fifo
`default_nettype none

// Parses one received SNMP packet, one byte per transfer, and reports the first
// varbind's OCTET STRING value as characters followed by a verdict on the last
// byte. A byte is taken every clock cycle as long as results are drained; each
// byte goes through an input register and the combinational parser, whose
// results enter the result queue. The only byte that yields two results (the
// string's final byte landing on the packet's final byte) is absorbed by the
// four-entry result queue; input stalls only when that queue holds more than two
// records. text_limit may be written whenever no packet is in flight.
module snmp_response_ber_parser_unit
    import snmp_ber_pkg::*;
#(
    parameter int MAX_PACKET = MAX_PACKET_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // data_byte[7:0], packet_length[16:8], zeros
    input  wire logic        s_tuser,   // first_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // text_char[7:0], response_ok[8], text_found[9],
                                        // text_length[17:10], zeros
    output logic             m_tuser,   // result_kind
    output logic             m_tlast,   // last_result
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data   // text_limit
);

    logic       in_valid_reg, in_valid_next;
    in_item_t   in_item_reg;
    logic [7:0] text_limit_reg, text_limit_next;
    logic       in_xfer;
    logic       fire;
    logic       room;
    logic [1:0] res_cnt;
    result_t    res0;
    result_t    res1;
    result_t    head;

    assign fire      = in_valid_reg && room;
    assign s_tready  = !in_valid_reg || room;
    assign in_xfer   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        in_valid_next   = in_xfer || (in_valid_reg && !fire);
        text_limit_next = (cfg_valid && cfg_ready) ? cfg_data : text_limit_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            text_limit_reg <= TEXT_LIMIT_RST;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            text_limit_reg <= text_limit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_item_reg.data_byte     <= s_tdata[7:0];
            in_item_reg.packet_length <= s_tdata[16:8];
            in_item_reg.first_byte    <= s_tuser;
        end
    end

    snmp_ber_parse #(
        .MAX_PACKET (MAX_PACKET)
    ) u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .item       (in_item_reg),
        .text_limit (text_limit_reg),
        .res_cnt    (res_cnt),
        .res0       (res0),
        .res1       (res1)
    );

    snmp_ber_fifo #(
        .DEPTH (RES_FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (res_cnt),
        .wr0       (res0),
        .wr1       (res1),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .head      (head)
    );

    assign m_tdata = {6'b000000, head.len, head.found, head.ok, head.ch};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule

`default_nettype wire
